// ----- rtl/tss_pkg.sv -----
// Types and constants for the triangle scanline span block.
// No dependencies; used by triangle_scanline_span.
`default_nettype none

package tss_pkg;

   localparam int unsigned CoordBits = 12;
   localparam int unsigned FracBits = 8;
   localparam int unsigned SpanBits = CoordBits + FracBits;

   typedef struct packed {
      logic [CoordBits-1:0] vert_a_x;
      logic [CoordBits-1:0] vert_a_y;
      logic [CoordBits-1:0] vert_b_x;
      logic [CoordBits-1:0] vert_b_y;
      logic [CoordBits-1:0] vert_c_x;
      logic [CoordBits-1:0] vert_c_y;
      logic [CoordBits-1:0] row_y;
   } req_type;

   typedef struct packed {
      logic                row_inside;
      logic [1:0]          crossing_count;
      logic [SpanBits-1:0] span_start;
      logic [SpanBits-1:0] span_end;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/tss_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing but its parameters; used by triangle_scanline_span.
`default_nettype none

module tss_divider #(
   parameter int unsigned NUM_BITS = 32,
   parameter int unsigned DEN_BITS = 12,
   parameter int unsigned TAG_BITS = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic [NUM_BITS-1:0] in_num,
   input  wire logic [DEN_BITS-1:0] in_den,
   input  wire logic [TAG_BITS-1:0] in_tag,
   output logic                     out_valid,
   output logic [NUM_BITS-1:0]      out_quot,
   output logic [TAG_BITS-1:0]      out_tag
);

   localparam int unsigned RemBits = DEN_BITS + 1;

   logic [NUM_BITS:0]     valid_ff;
   logic [NUM_BITS-1:0]   quot_ff [NUM_BITS+1];
   logic [RemBits-1:0]    rem_ff  [NUM_BITS+1];
   logic [DEN_BITS-1:0]   den_ff  [NUM_BITS+1];
   logic [TAG_BITS-1:0]   tag_ff  [NUM_BITS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[NUM_BITS-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      quot_ff[0] <= in_num;
      rem_ff[0]  <= '0;
      den_ff[0]  <= in_den;
      tag_ff[0]  <= in_tag;
   end

   // Each stage shifts in one numerator bit and tries one subtraction.
   for (genvar s = 0; s < NUM_BITS; s++) begin : g_stage
      logic [RemBits-1:0] trial_in;
      logic [RemBits:0]   diff_in;
      always_comb begin
         trial_in = {rem_ff[s][DEN_BITS-1:0], quot_ff[s][NUM_BITS-1]};
         diff_in  = {1'b0, trial_in} - {2'b00, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         den_ff[s+1] <= den_ff[s];
         tag_ff[s+1] <= tag_ff[s];
         if (!diff_in[RemBits]) begin
            rem_ff[s+1]  <= diff_in[RemBits-1:0];
            quot_ff[s+1] <= {quot_ff[s][NUM_BITS-2:0], 1'b1};
         end else begin
            rem_ff[s+1]  <= trial_in;
            quot_ff[s+1] <= {quot_ff[s][NUM_BITS-2:0], 1'b0};
         end
      end
   end

   assign out_valid = valid_ff[NUM_BITS];
   assign out_quot  = quot_ff[NUM_BITS];
   assign out_tag   = tag_ff[NUM_BITS];

endmodule

`default_nettype wire

// ----- rtl/triangle_scanline_span.sv -----
// Top level of the triangle scanline span block.
// Depends on tss_pkg and tss_divider.
//
// Usage: drive req_word with a triangle and a row and pulse start; busy is
// always low, so a word is taken at every clock edge where start is high.
// Each word gives exactly one result: rsp_word with rsp_strobe high for one
// cycle. Results leave in the order the words came in.
// The accepting edge registers the edge deltas. After it, one stage
// multiplies, the divider registers its inputs, and one divider stage
// follows per quotient bit. Then one stage applies the sign and one selects
// the first two crossings. Each edge has its own divider; the dividers run side by side.
// Throughput is one word per cycle.
// Reset clears every valid bit, so no result appears for words in flight.
// The receiver cannot stall; each result must be taken on its strobe.
`default_nettype none

module triangle_scanline_span (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire tss_pkg::req_type req_word,
   output logic                 rsp_strobe,
   output tss_pkg::rsp_type     rsp_word
);
   import tss_pkg::*;

   localparam int unsigned CB = CoordBits;
   localparam int unsigned SB = SpanBits;
   localparam int unsigned NumBits = 2 * CoordBits + FracBits;
   localparam int unsigned PB = 2 * CoordBits;
   localparam int unsigned TagBits = 1 + 1 + CB;

   logic [CB-1:0] ax, ay, bx, by, cx, cy, row;
   logic          accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign ax  = CB'(req_word.vert_a_x);
   assign ay  = CB'(req_word.vert_a_y);
   assign bx  = CB'(req_word.vert_b_x);
   assign by  = CB'(req_word.vert_b_y);
   assign cx  = CB'(req_word.vert_c_x);
   assign cy  = CB'(req_word.vert_c_y);
   assign row = CB'(req_word.row_y);

   // Row inside test, carried in its own delay line beside the edges.
   logic [CB-1:0] top_in, bot_in;
   logic          inside_in;
   always_comb begin
      top_in = ay;
      bot_in = ay;
      if (by < top_in) top_in = by;
      if (cy < top_in) top_in = cy;
      if (by > bot_in) bot_in = by;
      if (cy > bot_in) bot_in = cy;
      inside_in = (row > top_in) && (row < bot_in);
   end

   logic [CB-1:0] ex1 [3], ey1 [3], ex2 [3], ey2 [3];
   assign ex1[0] = ax; assign ey1[0] = ay; assign ex2[0] = bx; assign ey2[0] = by;
   assign ex1[1] = bx; assign ey1[1] = by; assign ex2[1] = cx; assign ey2[1] = cy;
   assign ex1[2] = cx; assign ey1[2] = cy; assign ex2[2] = ax; assign ey2[2] = ay;

   logic       s1_valid_ff;
   logic       s1_inside_ff;
   logic       s2_valid_ff;
   logic       s3_valid;
   logic [2:0] s3_hit;
   logic [SB-1:0] s3_x [3];
   logic          s3_inside;
   logic       s4_valid_ff;
   logic [2:0] s4_hit_ff;
   logic [SB-1:0] s4_x_ff [3];
   logic       s4_inside_ff;
   logic [2:0] div_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s4_valid_ff <= s3_valid;
      end
   end
   always_ff @(posedge clock) s1_inside_ff <= inside_in;

   for (genvar e = 0; e < 3; e++) begin : g_edge
      logic          hit_in;
      logic          neg_in;
      logic [CB-1:0] dx_in, dy_in, num_in;
      logic          s1_hit_ff, s1_neg_ff, s2_hit_ff, s2_neg_ff;
      logic [CB-1:0] s1_dx_ff, s1_dy_ff, s1_num_ff, s1_x1_ff, s2_dy_ff, s2_x1_ff;
      logic [PB-1:0] s2_prod_ff;
      logic [NumBits-1:0] quot;
      logic [TagBits-1:0] tag_out;
      logic [SB-1:0] base, q_s;

      always_comb begin
         hit_in = (ey1[e] != ey2[e]) &&
                  (row >= ((ey1[e] < ey2[e]) ? ey1[e] : ey2[e])) &&
                  (row <= ((ey1[e] < ey2[e]) ? ey2[e] : ey1[e]));
         dy_in  = (ey2[e] > ey1[e]) ? ey2[e] - ey1[e] : ey1[e] - ey2[e];
         num_in = (ey2[e] > ey1[e]) ? row - ey1[e] : ey1[e] - row;
         neg_in = ex2[e] < ex1[e];
         dx_in  = neg_in ? ex1[e] - ex2[e] : ex2[e] - ex1[e];
      end

      always_ff @(posedge clock) begin
         s1_hit_ff  <= hit_in;
         s1_neg_ff  <= neg_in;
         s1_dx_ff   <= dx_in;
         s1_dy_ff   <= dy_in;
         s1_num_ff  <= num_in;
         s1_x1_ff   <= ex1[e];
         s2_hit_ff  <= s1_hit_ff;
         s2_neg_ff  <= s1_neg_ff;
         s2_dy_ff   <= s1_dy_ff;
         s2_x1_ff   <= s1_x1_ff;
         s2_prod_ff <= {{CB{1'b0}}, s1_dx_ff} * {{CB{1'b0}}, s1_num_ff};
      end

      // A miss may carry a zero divisor; its quotient is never used.
      tss_divider #(
         .NUM_BITS(NumBits),
         .DEN_BITS(CB),
         .TAG_BITS(TagBits)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .in_valid (s2_valid_ff),
         .in_num   (NumBits'({s2_prod_ff, {FracBits{1'b0}}})),
         .in_den   (s2_dy_ff),
         .in_tag   ({s2_hit_ff, s2_neg_ff, s2_x1_ff}),
         .out_valid(div_valid[e]),
         .out_quot (quot),
         .out_tag  (tag_out)
      );

      always_comb begin
         base = {tag_out[CB-1:0], {FracBits{1'b0}}};
         q_s  = SB'(quot);
         s3_x[e]   = tag_out[CB] ? base - q_s : base + q_s;
         s3_hit[e] = tag_out[CB+1];
      end
   end

   // The inside flag rides a plain delay line matched to the multiply stage
   // and the divider, including the divider's input register.
   logic [NumBits+1:0] inside_dly_ff;
   always_ff @(posedge clock) begin
      inside_dly_ff <= {inside_dly_ff[NumBits:0], s1_inside_ff};
   end
   assign s3_inside = inside_dly_ff[NumBits+1];
   assign s3_valid  = div_valid[0];

   always_ff @(posedge clock) begin
      s4_hit_ff    <= s3_hit;
      s4_x_ff      <= s3_x;
      s4_inside_ff <= s3_inside;
   end

   rsp_type rsp_in;
   always_comb begin
      rsp_in = '0;
      rsp_in.row_inside = s4_inside_ff;
      rsp_in.crossing_count = 2'(s4_hit_ff[0]) + 2'(s4_hit_ff[1]) + 2'(s4_hit_ff[2]);
      priority if (s4_hit_ff[0]) begin
         rsp_in.span_start = SpanBits'(s4_x_ff[0]);
         if (s4_hit_ff[1])      rsp_in.span_end = SpanBits'(s4_x_ff[1]);
         else if (s4_hit_ff[2]) rsp_in.span_end = SpanBits'(s4_x_ff[2]);
      end else if (s4_hit_ff[1]) begin
         rsp_in.span_start = SpanBits'(s4_x_ff[1]);
         if (s4_hit_ff[2])      rsp_in.span_end = SpanBits'(s4_x_ff[2]);
      end else if (s4_hit_ff[2]) begin
         rsp_in.span_start = SpanBits'(s4_x_ff[2]);
      end else begin
         rsp_in.span_start = '0;
      end
   end

   logic    rsp_strobe_ff;
   rsp_type rsp_word_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else       rsp_strobe_ff <= s4_valid_ff;
   end
   always_ff @(posedge clock) rsp_word_ff <= rsp_in;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      div_valid[0] == div_valid[1] && div_valid[1] == div_valid[2])
      else $error("divider lanes out of step");
   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |=> rsp_strobe)
      else $error("result strobe lost");
   a_count_spans: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.crossing_count == 2'd0 |->
      rsp_word.span_start == '0 && rsp_word.span_end == '0)
      else $error("span without crossing");
   a_busy_low: assert property (@(posedge clock) !busy)
      else $error("busy raised");

endmodule

`default_nettype wire
